// ===== sv/planar_pose_odometry_integrator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// planar pose odometry integrator - assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH
`define PLANAR_POSE_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define PPOI_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PPOI_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== sv/ppoi_pkg.sv =====
// ----------------------------------------------------------------------------
// ppoi_pkg
// constants, tables, types and helpers of the pose odometry integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppoi_pkg;

  localparam int CORDIC_STEPS   = 16;
  localparam int QUAT_FRAC_BITS = 14;

  localparam int TABLE_LEN  = 30;
  localparam int ATAN_IDX_W = 5;
  localparam int STEP_W     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // 1/K in Q2.30
  localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;

  // atan(2^-i) in 2^32-per-turn units, truncated
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // accumulator keeps only the bits that reach the rounded Q16.16 delta
  localparam int ROUND_SH = 30;
  localparam int ACC_W    = ROUND_SH + 32;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (ROUND_SH - 1);

  localparam int QUAT_SH = 30 - QUAT_FRAC_BITS;
  localparam logic signed [32:0] QUAT_BIAS = (33'sd1 <<< QUAT_SH) >>> 1;
  localparam logic signed [32:0] QUAT_LIM  = 33'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [15:0] QUAT_OUT_MAX =
    (QUAT_FRAC_BITS >= 15) ? 16'sh7FFF : 16'(2 ** QUAT_FRAC_BITS);
  localparam logic signed [15:0] QUAT_OUT_MIN =
    (QUAT_FRAC_BITS >= 15) ? 16'sh8000 : 16'(-(2 ** QUAT_FRAC_BITS));

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_rsp_t;

  typedef struct packed {
    logic               mul_en;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    acc_op_t            acc_op;
  } mac_ctl_t;

  function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    return (idx < ATAN_IDX_W'(TABLE_LEN)) ? ATAN_TAB[idx] : 32'h0;
  endfunction

  // Q2.30 to Q1.QUAT_FRAC_BITS, round half up, then clamp
  function automatic logic [15:0] quat_fix(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = ($signed({v[31], v}) + QUAT_BIAS) >>> QUAT_SH;
    if (t > QUAT_LIM) begin
      t = QUAT_LIM;
    end else if (t < -QUAT_LIM) begin
      t = -QUAT_LIM;
    end
    if (t > 33'sd32767) begin
      t = 33'sd32767;
    end else if (t < -33'sd32768) begin
      t = -33'sd32768;
    end
    return t[15:0];
  endfunction

endpackage

// ===== sv/ppoi_cordic.sv =====
// ----------------------------------------------------------------------------
// ppoi_cordic
// rotation-mode cordic, one iteration per cycle, cos/sin in Q2.30
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppoi_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  ppoi_pkg::cordic_req_t req,
  output ppoi_pkg::cordic_rsp_t rsp
);
  import ppoi_pkg::*;

  logic                run_r;
  logic                done_r;
  logic                flip_r;
  logic [STEP_W-1:0]   step_r;
  logic signed [31:0]  x_r;
  logic signed [31:0]  y_r;
  logic signed [32:0]  z_r;

  logic signed [32:0]  z_in;
  logic signed [32:0]  z_fold;
  logic                fold;
  logic signed [31:0]  xs;
  logic signed [31:0]  ys;
  logic signed [32:0]  a_step;
  logic                dir_pos;
  logic signed [31:0]  x_step;
  logic signed [31:0]  y_step;
  logic signed [32:0]  z_step;
  logic                last_step;

  // bring the start angle into [-quarter turn, quarter turn]
  always_comb begin
    z_in = $signed({req.angle[31], req.angle});
    fold = 1'b1;
    if (z_in > 33'sd1073741824) begin
      z_fold = z_in - 33'sd2147483648;
    end else if (z_in < -33'sd1073741824) begin
      z_fold = z_in + 33'sd2147483648;
    end else begin
      z_fold = z_in;
      fold   = 1'b0;
    end
  end

  always_comb begin
    xs        = x_r >>> step_r;
    ys        = y_r >>> step_r;
    a_step    = $signed({1'b0, atan_lookup(ATAN_IDX_W'(step_r))});
    dir_pos   = ~z_r[32];
    x_step    = dir_pos ? (x_r - ys) : (x_r + ys);
    y_step    = dir_pos ? (y_r + xs) : (y_r - xs);
    z_step    = dir_pos ? (z_r - a_step) : (z_r + a_step);
    last_step = (step_r == STEP_W'(CORDIC_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && last_step) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= z_fold;
      flip_r <= fold;
      step_r <= '0;
    end else if (run_r) begin
      z_r <= z_step;
      if (last_step) begin
        x_r <= flip_r ? -x_step : x_step;
        y_r <= flip_r ? -y_step : y_step;
      end else begin
        x_r    <= x_step;
        y_r    <= y_step;
        step_r <= step_r + 1'b1;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = x_r;
  assign rsp.sin_v = y_r;

endmodule

// ===== sv/ppoi_mac.sv =====
// ----------------------------------------------------------------------------
// ppoi_mac
// shared 32x32 multiplier with registered product and rounding accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppoi_mac (
  input  logic               clk,
  input  ppoi_pkg::mac_ctl_t ctl,
  output logic [31:0]        acc_round
);
  import ppoi_pkg::*;

  logic signed [63:0] prod_full;
  logic [ACC_W-1:0]   prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;

  assign prod_full = ctl.mul_a * ctl.mul_b;

  always_comb begin
    case (ctl.acc_op)
      ACC_HOLD: acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = prod_r + ROUND_BIAS;  // round half up bias rides along
      ACC_SUB:  acc_nxt = acc_r - prod_r;
      ACC_ADD:  acc_nxt = acc_r + prod_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_full[ACC_W-1:0];
    end
    acc_r <= acc_nxt;
  end

  assign acc_round = acc_r[ACC_W-1:ROUND_SH];

endmodule

// ===== sv/planar_pose_odometry_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// planar_pose_odometry_integrator_unit
// midpoint odometry integrator: pose accumulation and yaw quaternion output
// ----------------------------------------------------------------------------
// One word in, one word out. A single cordic stepping one iteration per cycle
// runs twice per item, once for the midpoint rotation and once for the
// quaternion of the new heading, and one shared multiplier forms the four
// rotation products on consecutive cycles. in_stall is high for the whole
// item; a finished word waits in the output register while the next item is
// taken. Positions and heading reset to zero.
`timescale 1ns / 1ps

module planar_pose_odometry_integrator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_dx_local,
  input  logic signed [31:0] in_dy_local,
  input  logic signed [31:0] in_dtheta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w
);
  import ppoi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ROT,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_QUAT,
    S_WB
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [31:0] dx_r, dx_nxt;
  logic signed [31:0] dy_r, dy_nxt;
  logic signed [31:0] dth_r, dth_nxt;
  logic [31:0]        pos_x_r, pos_x_nxt;
  logic [31:0]        pos_y_r, pos_y_nxt;
  logic [31:0]        heading_r, heading_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_pos_x_r, out_pos_x_nxt;
  logic [31:0]        out_pos_y_r, out_pos_y_nxt;
  logic [31:0]        out_heading_r, out_heading_nxt;
  logic [15:0]        out_quat_z_r, out_quat_z_nxt;
  logic [15:0]        out_quat_w_r, out_quat_w_nxt;

  logic [31:0]        dth_half;
  logic [31:0]        mid;
  logic [31:0]        delta;
  cordic_req_t        cordic_req;
  cordic_rsp_t        cordic_rsp;
  mac_ctl_t           mac_ctl;

  ppoi_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .rsp   (cordic_rsp)
  );

  ppoi_mac u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .acc_round (delta)
  );

  assign dth_half = dth_r >>> 1;
  assign mid      = heading_r + dth_half;

  always_comb begin
    state_nxt       = state_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    dth_nxt         = dth_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    heading_nxt     = heading_r;
    out_valid_nxt   = out_valid_r;
    out_pos_x_nxt   = out_pos_x_r;
    out_pos_y_nxt   = out_pos_y_r;
    out_heading_nxt = out_heading_r;
    out_quat_z_nxt  = out_quat_z_r;
    out_quat_w_nxt  = out_quat_w_r;

    cordic_req.start = 1'b0;
    cordic_req.angle = '0;
    mac_ctl.mul_en   = 1'b0;
    mac_ctl.mul_a    = dx_r;
    mac_ctl.mul_b    = cordic_rsp.cos_v;
    mac_ctl.acc_op   = ACC_HOLD;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dx_nxt    = in_dx_local;
          dy_nxt    = in_dy_local;
          dth_nxt   = in_dtheta;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // midpoint heading read at half-turn scale
        cordic_req.start = 1'b1;
        cordic_req.angle = {mid[30:0], 1'b0};
        state_nxt        = S_ROT;
      end
      S_ROT: begin
        if (cordic_rsp.done) begin
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.mul_a  = dx_r;
        mac_ctl.mul_b  = cordic_rsp.cos_v;
        state_nxt      = S_M1;
      end
      S_M1: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.mul_a  = dy_r;
        mac_ctl.mul_b  = cordic_rsp.sin_v;
        mac_ctl.acc_op = ACC_LOAD;
        state_nxt      = S_M2;
      end
      S_M2: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.mul_a  = dx_r;
        mac_ctl.mul_b  = cordic_rsp.sin_v;
        mac_ctl.acc_op = ACC_SUB;
        state_nxt      = S_M3;
      end
      S_M3: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.mul_a  = dy_r;
        mac_ctl.mul_b  = cordic_rsp.cos_v;
        mac_ctl.acc_op = ACC_LOAD;
        pos_x_nxt      = pos_x_r + delta;
        state_nxt      = S_M4;
      end
      S_M4: begin
        mac_ctl.acc_op = ACC_ADD;
        heading_nxt    = heading_r + dth_r;
        state_nxt      = S_M5;
      end
      S_M5: begin
        pos_y_nxt        = pos_y_r + delta;
        cordic_req.start = 1'b1;
        cordic_req.angle = heading_r;
        state_nxt        = S_QUAT;
      end
      S_QUAT: begin
        if (cordic_rsp.done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_pos_x_nxt   = pos_x_r;
          out_pos_y_nxt   = pos_y_r;
          out_heading_nxt = heading_r;
          out_quat_z_nxt  = quat_fix(cordic_rsp.sin_v);
          out_quat_w_nxt  = quat_fix(cordic_rsp.cos_v);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    dth_r         <= dth_nxt;
    out_pos_x_r   <= out_pos_x_nxt;
    out_pos_y_r   <= out_pos_y_nxt;
    out_heading_r <= out_heading_nxt;
    out_quat_z_r  <= out_quat_z_nxt;
    out_quat_w_r  <= out_quat_w_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_pos_x_r;
  assign out_pos_y   = out_pos_y_r;
  assign out_heading = out_heading_r;
  assign out_quat_z  = out_quat_z_r;
  assign out_quat_w  = out_quat_w_r;

endmodule

// ===== sv/ppoi_checker.sv =====
// ----------------------------------------------------------------------------
// ppoi_checker
// port-level checks of the pose odometry integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "planar_pose_odometry_integrator_unit_macros.svh"

module ppoi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pos_x,
  input logic signed [15:0] out_quat_z,
  input logic signed [15:0] out_quat_w
);
  import ppoi_pkg::*;

  // a taken word keeps the block busy on the next cycle
  `PPOI_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "not busy after accept")

  // a fresh result only comes out of a busy cycle
  `PPOI_ASSERT(a_result_from_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result without work")

  // stalled result word holds
  `PPOI_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_pos_x), "stalled word changed")

  // quaternion components stay within unit range
  `PPOI_ASSERT(a_quat_range, clk, rst_n, out_valid |-> (out_quat_z <= QUAT_OUT_MAX) && (out_quat_z >= QUAT_OUT_MIN) && (out_quat_w <= QUAT_OUT_MAX) && (out_quat_w >= QUAT_OUT_MIN), "quaternion out of range")

  `PPOI_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "valid after reset")

endmodule

bind planar_pose_odometry_integrator_unit ppoi_checker u_ppoi_checker (.*);

// ===== bench/tb_planar_pose_odometry_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_planar_pose_odometry_integrator_unit
// Directed corner steps, then about a thousand random odometry steps. A
// behavioral pose predictor computes each expected pose, and a scoreboard
// checks every output word field by field. Both channels stall in random
// bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_planar_pose_odometry_integrator_unit;
  import ppoi_pkg::*;

  localparam int N_RANDOM  = 1000;
  localparam int CALM_TAIL = 150;
  localparam int WATCHDOG  = 4000;
  localparam int TAIL_WAIT = 100;

  typedef struct {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dth;
    bit                 drain;
  } odo_step_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
  } pose_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_dx_local;
  logic signed [31:0] in_dy_local;
  logic signed [31:0] in_dtheta;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic [31:0]        out_heading;
  logic signed [15:0] out_quat_z;
  logic signed [15:0] out_quat_w;

  odo_step_t   pending_steps[$];
  pose_t       expected_poses[$];
  logic [31:0] odo_x       = '0;
  logic [31:0] odo_y       = '0;
  logic [31:0] odo_heading = '0;
  bit          in_fire;
  int          n_items;
  int          n_accepted;
  int          n_results;
  int          n_errors;
  int          idle_cycles;
  int          in_gap;
  int          out_gap;

  planar_pose_odometry_integrator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_dx_local (in_dx_local),
    .in_dy_local (in_dy_local),
    .in_dtheta   (in_dtheta),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_heading (out_heading),
    .out_quat_z  (out_quat_z),
    .out_quat_w  (out_quat_w)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // rotation-mode cordic, angle 2^32 per turn, cos/sin in q2.30
  function automatic void cordic_rotate(input logic [31:0] angle, output longint cos_q30,
                                        output longint sin_q30);
    longint z;
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint a;
    bit     flip;
    z    = longint'($signed(angle));
    x    = longint'(CORDIC_GAIN);
    y    = 0;
    flip = 1'b0;
    // fold into the right half plane, undo by negating at the end
    if (z > 64'sd1073741824) begin
      z    = z - 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z    = z + 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      a  = (i < TABLE_LEN) ? longint'(ATAN_TAB[i]) : 0;
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - a;
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + a;
      end
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  function automatic logic [31:0] round_q30(input longint p);
    longint r;
    r = (p + (64'sd1 <<< 29)) >>> 30;
    return r[31:0];
  endfunction

  function automatic logic [15:0] to_quat(input longint v);
    longint lim;
    int     sh;
    sh = 30 - QUAT_FRAC_BITS;
    if (sh > 0) begin
      v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    lim = 64'sd1 <<< QUAT_FRAC_BITS;
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  // advances the tracked pose by one step and returns the pose word
  function automatic pose_t integrate_step(input logic signed [31:0] dx,
                                           input logic signed [31:0] dy,
                                           input logic signed [31:0] dth);
    pose_t       res;
    logic [31:0] mid;
    logic [31:0] rot;
    longint      c;
    longint      s;
    mid = odo_heading + 32'(dth >>> 1);
    rot = mid << 1;
    cordic_rotate(rot, c, s);
    odo_x       = odo_x + round_q30(longint'(dx) * c - longint'(dy) * s);
    odo_y       = odo_y + round_q30(longint'(dx) * s + longint'(dy) * c);
    odo_heading = odo_heading + dth;
    // quaternion uses the new heading as a half angle
    cordic_rotate(odo_heading, c, s);
    res.pos_x   = odo_x;
    res.pos_y   = odo_y;
    res.heading = odo_heading;
    res.quat_z  = to_quat(s);
    res.quat_w  = to_quat(c);
    return res;
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      4: return 32'hFFFF_FFFF;
      5: return 32'h4000_0000;
      6: return 32'hC000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic odo_step_t random_step();
    odo_step_t   s;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      s.dx  = $urandom();
      s.dy  = $urandom();
      s.dth = $urandom();
    end else if (pick < 8) begin
      // realistic small motion
      s.dx  = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      s.dy  = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      s.dth = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    end else begin
      s.dx  = corner_word();
      s.dy  = corner_word();
      s.dth = corner_word();
    end
    s.drain = 1'b0;
    return s;
  endfunction

  function automatic void add_step(input logic [31:0] dx, input logic [31:0] dy,
                                   input logic [31:0] dth);
    odo_step_t s;
    s.dx    = dx;
    s.dy    = dy;
    s.dth   = dth;
    s.drain = 1'b0;
    pending_steps.push_back(s);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      n_errors++;
    end
  endfunction

  // input driver: holds a word until accepted, then sends the next one
  always @(negedge clk) begin
    odo_step_t nxt;
    logic      drive;
    if (rst_n) begin
      drive = in_valid && !in_fire;
      if (!drive) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_steps.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(1, 16) - 1;
        end else if (pending_steps.size() != 0 &&
                     !(pending_steps[0].drain && expected_poses.size() != 0)) begin
          nxt = pending_steps.pop_front();
          in_dx_local <= nxt.dx;
          in_dy_local <= nxt.dy;
          in_dtheta   <= nxt.dth;
          drive = 1'b1;
        end
      end
      in_valid <= drive;
    end
  end

  // result-side back pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
      end else if (pending_steps.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(1, 16);
      end
      out_stall <= (out_gap > 0);
    end
  end

  // predictor and scoreboard
  always @(posedge clk) begin
    pose_t want;
    logic  took_in;
    logic  took_out;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      took_in  = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      in_fire <= took_in;
      if (took_in) begin
        expected_poses.push_back(integrate_step(in_dx_local, in_dy_local, in_dtheta));
        n_accepted++;
      end
      if (took_out) begin
        if (expected_poses.size() == 0) begin
          $error("pose word with no step outstanding");
          n_errors++;
        end else begin
          want = expected_poses.pop_front();
          check_field("pos_x", want.pos_x, out_pos_x);
          check_field("pos_y", want.pos_y, out_pos_y);
          check_field("heading", want.heading, out_heading);
          check_field("quat_z", {16'h0, want.quat_z}, {16'h0, out_quat_z});
          check_field("quat_w", {16'h0, want.quat_w}, {16'h0, out_quat_w});
          n_results++;
        end
      end
      idle_cycles = (took_in || took_out) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG) begin
      @(negedge clk);
    end
    $display("tb_planar_pose_odometry_integrator_unit failed");
    $finish;
  end

  initial begin
    odo_step_t s;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    in_dx_local = '0;
    in_dy_local = '0;
    in_dtheta   = '0;

    // directed corners
    add_step(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_step(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    add_step(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    add_step(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    add_step(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
    // position wrap on repeated full-scale motion
    add_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
    add_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
    // world delta wider than 32 bits near 45 degrees
    add_step(32'h7FFF_FFFF, 32'h8000_0000, 32'h2000_0000);
    add_step(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    add_step(32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    add_step(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
    add_step(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
    add_step(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    // quarter-turn steps walk through the fold boundaries and wrap heading
    for (int i = 0; i < 5; i++) begin
      add_step(32'h0010_0000, 32'hFFF0_0000, 32'h4000_0000);
    end
    add_step(32'h0000_8000, 32'h0000_8000, 32'hC000_0000);
    add_step(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_step(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555);

    for (int i = 0; i < N_RANDOM; i++) begin
      s = random_step();
      // let the pipeline run dry before some steps
      s.drain = (i == 0 || i == N_RANDOM / 2);
      pending_steps.push_back(s);
    end
    n_items = pending_steps.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_items || expected_poses.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_WAIT) @(negedge clk);

    $display("covered %0d odometry steps (full-scale, small-motion and corner words)",
             n_accepted);
    $display("checked %0d pose words, %0d field mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb_planar_pose_odometry_integrator_unit passed");
    end else begin
      $display("tb_planar_pose_odometry_integrator_unit failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ppoi_pkg.sv
sv/ppoi_cordic.sv
sv/ppoi_mac.sv
sv/planar_pose_odometry_integrator_unit.sv
sv/ppoi_checker.sv
bench/tb_planar_pose_odometry_integrator_unit.sv
